// File: sv/number_to_ascii_formatter_top_defines.svh
// assertion macros shared by the formatter modules
// needs clk and rst in scope at the point of use
`ifndef NUMBER_TO_ASCII_FORMATTER_TOP_DEFINES_SVH
`define NUMBER_TO_ASCII_FORMATTER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define NTA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define NTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/nta_pkg.sv
// shared types, sizes and character helpers for the number formatter
// no dependencies
`timescale 1ns / 1ps

package nta_pkg;

  localparam int VALUE_BITS = 32;
  // decimal digits needed for a VALUE_BITS-bit magnitude
  localparam int DEC_DIGITS = (VALUE_BITS * 301) / 1000 + 1;
  localparam int BCD_W      = 4 * DEC_DIGITS;
  localparam int EMIT_MAX   = (DEC_DIGITS > 8) ? DEC_DIGITS : 8;
  localparam int CNT_W      = $clog2(EMIT_MAX + 1);
  localparam int DAB_CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int DEC4_BITS  = 16;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_A     = 8'h41;

  typedef enum logic [1:0] {
    OP_SDEC = 2'd0,
    OP_BIN  = 2'd1,
    OP_HEX  = 2'd2,
    OP_DEC4 = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_LAUNCH
  } state_t;

  // start of a bit-serial conversion
  typedef struct packed {
    logic                  start;
    logic [DAB_CNT_W-1:0]  nbits;
    logic [VALUE_BITS-1:0] bits;
  } dab_cmd_t;

  // one item handed to the character sequencer
  typedef struct packed {
    logic             start;
    op_t              op;
    logic             neg;
    logic [7:0]       low_byte;
    logic [BCD_W-1:0] bcd;
  } nta_job_t;

  function automatic logic [7:0] dec_char(input logic [3:0] d);
    dec_char = CH_ZERO + {4'b0000, d};
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      hex_char = CH_ZERO + {4'b0000, nib};
    end else begin
      hex_char = CH_A + {4'b0000, nib} - 8'd10;
    end
  endfunction

endpackage

// File: sv/number_to_ascii_formatter_top.sv
// number to ascii formatter, top level: input beat, sign handling and control
// depends on nta_pkg, nta_dabble, nta_emit and the shared assertion macros
`timescale 1ns / 1ps
`include "number_to_ascii_formatter_top_defines.svh"

// signed and four-digit decimal numbers pass through the bit-serial bcd conversion before
//   the sequencer starts; binary and hex go straight to the sequencer via the launch state
// then one character per cycle while the output is not stalled; signed decimal drops
// leading zeros, each in a step of its own with no beat
// the next item is taken as soon as the last character sits in the output register
// rst is synchronous and clears the control state only; no clearing pass
module number_to_ascii_formatter_top import nta_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   op,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   character,
  output logic                         last
);

  state_t state;
  state_t state_next;

  // item fields held while the conversion runs
  op_t        op_r;
  logic       neg_r;
  logic [7:0] low_r;

  logic                  in_accept;
  op_t                   op_in;
  logic [VALUE_BITS-1:0] value_u;
  logic [VALUE_BITS-1:0] mag;
  dab_cmd_t              dab_cmd;
  logic                  dab_busy;
  logic                  dab_done;
  logic [BCD_W-1:0]      dab_bcd;
  nta_job_t              job;
  logic                  emit_busy;

  assign op_in     = op_t'(op);
  assign value_u   = value;
  assign in_accept = in_valid && !in_stall;

  // unsigned magnitude, so the most negative value converts correctly
  assign mag = value_u[VALUE_BITS-1] ? (~value_u + 1'b1) : value_u;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (op_in == OP_SDEC || op_in == OP_DEC4) begin
            state_next = ST_CONV;
          end else begin
            state_next = ST_LAUNCH;
          end
        end
      end
      ST_CONV: begin
        if (dab_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_LAUNCH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_stall      = (state != ST_IDLE) || emit_busy;
    dab_cmd.start = in_accept && (op_in == OP_SDEC || op_in == OP_DEC4);
    if (op_in == OP_DEC4) begin
      dab_cmd.nbits = DAB_CNT_W'(DEC4_BITS);
      dab_cmd.bits  = VALUE_BITS'(value_u[DEC4_BITS-1:0]) << (VALUE_BITS - DEC4_BITS);
    end else begin
      dab_cmd.nbits = DAB_CNT_W'(VALUE_BITS);
      dab_cmd.bits  = mag;
    end
    job.start    = (state == ST_CONV && dab_done) || (state == ST_LAUNCH);
    job.op       = op_r;
    job.neg      = neg_r;
    job.low_byte = low_r;
    job.bcd      = dab_bcd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r  <= op_in;
      neg_r <= value_u[VALUE_BITS-1];
      low_r <= value_u[7:0];
    end
  end

  // bit-serial binary to bcd
  nta_dabble u_dabble (
    .clk  (clk),
    .rst  (rst),
    .cmd  (dab_cmd),
    .busy (dab_busy),
    .done (dab_done),
    .bcd  (dab_bcd)
  );

  // one character per beat into the output register
  nta_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .busy      (emit_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

  `NTA_ASSERT_NOW(a_conv_runs, state == ST_CONV, dab_busy || dab_done, "waiting on idle converter")
  `NTA_ASSERT_NOW(a_done_in_conv, dab_done, state == ST_CONV, "conversion finished unexpectedly")
  `NTA_ASSERT_NEXT(a_launch_busy, job.start, emit_busy, "sequencer did not take the item")

endmodule

// File: sv/nta_dabble.sv
// bit-serial binary to bcd conversion, one input bit per cycle (shift and add 3)
// depends on nta_pkg and the shared assertion macros
`timescale 1ns / 1ps
`include "number_to_ascii_formatter_top_defines.svh"

module nta_dabble import nta_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  dab_cmd_t         cmd,
  output logic             busy,
  output logic             done,
  output logic [BCD_W-1:0] bcd
);

  logic [VALUE_BITS-1:0] sr;
  logic [DAB_CNT_W-1:0]  cnt;
  logic [BCD_W-1:0]      adj;

  // digits of five or more get 3 before the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.nbits;
        sr   <= cmd.bits;
        bcd  <= '0;
      end else if (busy) begin
        bcd <= {adj[BCD_W-2:0], sr[VALUE_BITS-1]};
        sr  <= sr << 1;
        cnt <= cnt - 1'b1;
        if (cnt == DAB_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  `NTA_ASSERT_NOW(a_done_not_busy, done, !busy, "dabble done while still converting")
  `NTA_ASSERT_NOW(a_busy_count, busy, cnt != '0, "dabble running with empty bit count")

endmodule

// File: sv/nta_emit.sv
// character sequencer: walks the bcd digits or the low byte one character per beat
// depends on nta_pkg and the shared assertion macros
`timescale 1ns / 1ps
`include "number_to_ascii_formatter_top_defines.svh"

module nta_emit import nta_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  nta_job_t   job,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] character,
  output logic       last
);

  op_t              op_r;
  logic             neg_r;
  logic [7:0]       low_r;
  logic [BCD_W-1:0] bcd_r;
  logic [CNT_W-1:0] cnt;
  logic             started;

  logic       slot_free;
  logic       emit_c;
  logic       shift_bcd;
  logic       shift_low;
  logic       dec_cnt;
  logic       clr_neg;
  logic       last_c;
  logic [7:0] ch_c;
  logic [3:0] digit;

  assign slot_free = !out_valid || !out_stall;
  assign digit     = bcd_r[BCD_W-1 -: 4];

  always_comb begin
    emit_c    = 1'b1;
    shift_bcd = 1'b0;
    shift_low = 1'b0;
    dec_cnt   = 1'b0;
    clr_neg   = 1'b0;
    ch_c      = CH_ZERO;
    case (op_r)
      OP_SDEC: begin
        if (neg_r) begin
          ch_c    = CH_MINUS;
          clr_neg = 1'b1;
        end else if (!started && digit == 4'd0 && cnt != CNT_W'(1)) begin
          // leading zero, dropped without a beat
          emit_c    = 1'b0;
          shift_bcd = 1'b1;
          dec_cnt   = 1'b1;
        end else begin
          ch_c      = dec_char(digit);
          shift_bcd = 1'b1;
          dec_cnt   = 1'b1;
        end
      end
      OP_BIN: begin
        ch_c      = low_r[7] ? CH_ZERO + 8'd1 : CH_ZERO;
        shift_low = 1'b1;
        dec_cnt   = 1'b1;
      end
      OP_HEX: begin
        if (cnt == CNT_W'(4)) begin
          ch_c = CH_ZERO;
        end else if (cnt == CNT_W'(3)) begin
          ch_c = CH_X;
        end else if (cnt == CNT_W'(2)) begin
          ch_c = hex_char(low_r[7:4]);
        end else begin
          ch_c = hex_char(low_r[3:0]);
        end
        dec_cnt = 1'b1;
      end
      OP_DEC4: begin
        ch_c      = dec_char(digit);
        shift_bcd = 1'b1;
        dec_cnt   = 1'b1;
      end
      default: begin
        emit_c = 1'b0;
      end
    endcase
    last_c = emit_c && dec_cnt && (cnt == CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
      started   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (job.start) begin
        busy     <= 1'b1;
        op_r     <= job.op;
        neg_r    <= job.neg && (job.op == OP_SDEC);
        low_r    <= job.low_byte;
        started  <= (job.op != OP_SDEC);
        // four-digit mode keeps only the low four digits, left aligned
        if (job.op == OP_DEC4) begin
          bcd_r <= BCD_W'(job.bcd[15:0]) << (BCD_W - 16);
        end else begin
          bcd_r <= job.bcd;
        end
        case (job.op)
          OP_SDEC: cnt <= CNT_W'(DEC_DIGITS);
          OP_BIN:  cnt <= CNT_W'(8);
          default: cnt <= CNT_W'(4);
        endcase
      end else if (busy && slot_free) begin
        if (emit_c) begin
          out_valid <= 1'b1;
          character <= ch_c;
          last      <= last_c;
        end
        if (dec_cnt) begin
          cnt <= cnt - 1'b1;
        end
        if (shift_bcd) begin
          bcd_r <= bcd_r << 4;
        end
        if (shift_low) begin
          low_r <= low_r << 1;
        end
        if (clr_neg) begin
          neg_r <= 1'b0;
        end
        if (emit_c && shift_bcd) begin
          started <= 1'b1;
        end
        if (last_c) begin
          busy <= 1'b0;
        end
      end
    end
  end

  `NTA_ASSERT_NOW(a_idle_count, !busy, cnt == '0, "sequencer idle with characters left")
  `NTA_ASSERT_NOW(a_char_set, out_valid,
    (character >= CH_ZERO && character <= CH_ZERO + 8'd9) ||
    (character >= CH_A && character <= CH_A + 8'd5) ||
    character == CH_X || character == CH_MINUS, "character outside the output set")

endmodule

// File: sim/tb_top.sv
// testbench for number_to_ascii_formatter_top: directed and random numbers in all four formats,
// predicted character runs checked beat by beat under random and long output stalls
// depends on nta_pkg and the formatter rtl
`timescale 1ns / 1ps

module tb_top;
  import nta_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  // cycles to wait after the last expected character; covers a full decimal conversion
  localparam int TAIL_CYCLES = 60;

  // one expected output beat
  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } ascii_beat_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [1:0]                   op_sel = 2'd0;
  logic signed [VALUE_BITS-1:0] number = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [7:0]                   character;
  logic                         last;

  // characters still owed by the block, oldest first
  ascii_beat_t expected_chars [$];

  int mismatch_count = 0;
  int cycle_count = 0;
  // largest random gap of the sender and of the receiver, set per test
  int tx_max_gap = 0;
  int rx_max_gap = 0;
  // long receiver hold-off, counted down by the receiver process
  int hold_left = 0;
  int stall_left = 0;

  number_to_ascii_formatter_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op_sel),
    .value     (number),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters outstanding", cycle_count,
               expected_chars.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // works out the character run of one accepted number and queues it
  function automatic void predict_characters(input op_t fmt, input logic [VALUE_BITS-1:0] v);
    logic [7:0]            run [$];
    logic [7:0]            digits [$];
    logic [VALUE_BITS-1:0] mag;
    logic [3:0]            nib;
    int unsigned           rem;
    ascii_beat_t           b;
    case (fmt)
      OP_SDEC: begin
        // magnitude taken unsigned so the most negative value needs no special path
        mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
        if (v[VALUE_BITS-1]) run.push_back(CH_MINUS);
        do begin
          digits.push_front(CH_ZERO + 8'(mag % 10));
          mag = mag / 10;
        end while (mag != 0);
        foreach (digits[i]) run.push_back(digits[i]);
      end
      OP_BIN: begin
        for (int i = 7; i >= 0; i--) run.push_back(CH_ZERO + {7'd0, v[i]});
      end
      OP_HEX: begin
        run.push_back(CH_ZERO);
        run.push_back(CH_X);
        for (int i = 1; i >= 0; i--) begin
          nib = v[4*i +: 4];
          run.push_back(nib < 4'd10 ? CH_ZERO + {4'd0, nib} : CH_A + {4'd0, nib} - 8'd10);
        end
      end
      default: begin
        // low 16 bits unsigned, folded to four zero-padded digits
        rem = v[15:0] % 10000;
        run.push_back(CH_ZERO + 8'(rem / 1000));
        run.push_back(CH_ZERO + 8'((rem / 100) % 10));
        run.push_back(CH_ZERO + 8'((rem / 10) % 10));
        run.push_back(CH_ZERO + 8'(rem % 10));
      end
    endcase
    foreach (run[i]) begin
      b.ch  = run[i];
      b.fin = (i == run.size() - 1);
      expected_chars.push_back(b);
    end
  endfunction

  // offers one number after a random gap and waits for the accepting edge;
  // valid stays high into the next call so back-to-back beats need no extra step
  task automatic offer_number(input op_t fmt, input logic [VALUE_BITS-1:0] v);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op_sel   <= fmt;
    number   <= v;
    do @(posedge clk); while (in_stall);
    predict_characters(fmt, v);
  endtask

  // receiver: after every taken beat draw a stall length; a requested hold-off wins
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) stall_left = $urandom_range(0, rx_max_gap);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // checker: every taken beat against the oldest expected character
  always @(posedge clk) begin
    ascii_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat char=%02h last=%b", character, last));
      end else begin
        want = expected_chars.pop_front();
        if (character !== want.ch)
          flag_mismatch($sformatf("character got %02h want %02h", character, want.ch));
        if (last !== want.fin)
          flag_mismatch($sformatf("last got %b want %b on char %02h", last, want.fin, want.ch));
      end
    end
  end

  // random number with weight on the interesting corners of the decimal path
  function automatic logic [VALUE_BITS-1:0] pick_number();
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] p;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 40) - 20;
      2: begin
        // around a power of ten, either sign
        p = 1;
        repeat ($urandom_range(0, 9)) p = p * 10;
        v = p + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
      3: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h8000_0001;
          3: v = 32'hffff_ffff;
          default: v = '0;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic offer_random(input int count);
    for (int i = 0; i < count; i++) offer_number(op_t'($urandom_range(0, 3)), pick_number());
  endtask

  // corners of every format, upper bits of byte formats randomized
  task automatic test_directed();
    logic [31:0] hi;
    hi = $urandom;
    tx_max_gap = 4;
    rx_max_gap = 4;
    offer_number(OP_SDEC, 32'd0);
    offer_number(OP_SDEC, 32'd1);
    offer_number(OP_SDEC, -32'sd1);
    offer_number(OP_SDEC, 32'd9);
    offer_number(OP_SDEC, 32'd10);
    offer_number(OP_SDEC, -32'sd10);
    offer_number(OP_SDEC, 32'd1000000000);
    offer_number(OP_SDEC, 32'h7fff_ffff);
    // most negative value, eleven characters
    offer_number(OP_SDEC, 32'h8000_0000);
    offer_number(OP_BIN, {hi[31:8], 8'h00});
    offer_number(OP_BIN, {~hi[31:8], 8'hff});
    offer_number(OP_BIN, {hi[31:8], 8'ha5});
    offer_number(OP_HEX, {hi[31:8], 8'h00});
    offer_number(OP_HEX, {~hi[31:8], 8'hff});
    offer_number(OP_HEX, {hi[31:8], 8'h9a});
    offer_number(OP_HEX, {hi[31:8], 8'hbc});
    offer_number(OP_HEX, {hi[31:8], 8'hde});
    offer_number(OP_DEC4, 32'd0);
    offer_number(OP_DEC4, 32'd9999);
    offer_number(OP_DEC4, 32'd10000);
    offer_number(OP_DEC4, 32'h0000_ffff);
    // upper half ignored: 0x5678 folds to 2136
    offer_number(OP_DEC4, 32'h1234_5678);
  endtask

  // full rate on both sides
  task automatic test_no_idle();
    tx_max_gap = 0;
    rx_max_gap = 0;
    offer_random(60);
  endtask

  // random gaps on both sides
  task automatic test_random_idle();
    tx_max_gap = 16;
    rx_max_gap = 16;
    offer_random(150);
  endtask

  // one-sided idling, then the other side
  task automatic test_one_sided();
    tx_max_gap = 16;
    rx_max_gap = 0;
    offer_random(20);
    tx_max_gap = 0;
    rx_max_gap = 16;
    offer_random(20);
  endtask

  // receiver holds off for a long stretch while the sender keeps pushing,
  // so the block backs up and stalls its input
  task automatic test_backpressure();
    tx_max_gap = 0;
    rx_max_gap = 2;
    hold_left = 300;
    offer_random(20);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_no_idle();
    test_random_idle();
    test_one_sided();
    test_backpressure();
    in_valid <= 1'b0;
    // drain, then give the block time to show any stray beats
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
